// ----- rtl/hnorm_pkg.sv -----
// shared types, constants and widths for the heightmap normal generator
`default_nettype none
package hnorm_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int BASE_W = 16;
	localparam int IMGW_W = 11;
	localparam int LEN_W  = 16;
	localparam int SMP_W  = 8;
	localparam int HGT_W  = 16;
	localparam int DIFF_W = 17;
	localparam int NORM_W = 18;
	localparam int UNIT_W = 16;
	localparam int SQ_W   = 32;
	localparam int NSUM_W = 33;
	localparam int QUO_W  = 28;
	localparam int ROOT_W = 14;
	localparam int SREM_W = 18;
	localparam int PROD_W = 24;
	localparam int RCP_W  = 25;
	localparam int RCP_SH = 32;

	localparam logic [BASE_W-1:0] BASE_RST = 16'd256;
	localparam logic [IMGW_W-1:0] IMGW_RST = 11'd1024;
	localparam logic [LEN_W-1:0]  LEN_RST  = 16'd1024;

	// ceil(2^32 / 255), exact for every base_height * sample + 127
	localparam logic [RCP_W-1:0]  RECIP_255 = 25'd16843010;
	localparam logic [PROD_W-1:0] ROUND_ADD = 24'd127;
	localparam logic [NSUM_W-1:0] ONE_SQ    = 33'd65536;
	// full unit length, only reached by the y part of a flat face
	localparam logic [UNIT_W-1:0] UNIT_ONE  = 16'd16384;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_LENGTH = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
		ST_HMUL, ST_HDIV, ST_FSEL, ST_FWAIT, ST_EMIT
	} hn_state_t;

	typedef enum logic [2:0] {
		F_IDLE, F_SQ, F_NRM, F_LOAD, F_DIV, F_SQRT, F_STORE
	} face_state_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] a;
		logic signed [DIFF_W-1:0] b;
	} face_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [UNIT_W-1:0] x;
		logic signed [UNIT_W-1:0] y;
		logic signed [UNIT_W-1:0] z;
	} face_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/hnorm_face.sv -----
// normalizes one face vector (a, 256, b) by bit-serial division and square root
`default_nettype none
module hnorm_face (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hnorm_pkg::face_req_t  req,
	output hnorm_pkg::face_rsp_t       rsp,
	output logic                       busy
);
	import hnorm_pkg::*;

	localparam logic [4:0] DIV_LAST  = 5'(QUO_W - 1);
	localparam logic [4:0] SQRT_LAST = 5'(ROOT_W - 1);

	face_state_t state_q, state_d;

	logic signed [DIFF_W-1:0] a_q, b_q;
	logic [SQ_W-1:0]   a2_q, b2_q;
	logic [NSUM_W-1:0] n_q, rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic [1:0]        k_q;
	logic signed [UNIT_W-1:0] ux_q, uy_q, uz_q;
	logic              done_q;

	logic [DIFF_W-1:0] mag_a, mag_b;
	logic [NSUM_W-1:0] csq;
	logic [NSUM_W:0]   r2, r2_sub;
	logic              r2_ge;
	logic [SREM_W-1:0] s_in, s_trial;
	logic              s_ge;
	logic              neg;
	logic [UNIT_W-1:0] umag;
	logic signed [UNIT_W-1:0] uval;

	assign mag_a = a_q[DIFF_W-1] ? DIFF_W'(-a_q) : a_q;
	assign mag_b = b_q[DIFF_W-1] ? DIFF_W'(-b_q) : b_q;

	always_comb begin
		unique case (k_q)
			2'd0:    csq = {1'b0, a2_q};
			2'd1:    csq = ONE_SQ;
			default: csq = {1'b0, b2_q};
		endcase
	end

	assign r2      = {rem_q, 1'b0};
	assign r2_ge   = r2 >= {1'b0, n_q};
	assign r2_sub  = r2 - {1'b0, n_q};
	assign s_in    = {srem_q[SREM_W-3:0], quo_q[QUO_W-1 -: 2]};
	assign s_trial = {2'b00, root_q, 2'b01};
	assign s_ge    = s_in >= s_trial;
	assign neg     = (k_q == 2'd0) ? a_q[DIFF_W-1] : (k_q == 2'd2) ? b_q[DIFF_W-1] : 1'b0;
	assign umag    = (k_q == 2'd1 && n_q == ONE_SQ) ? UNIT_ONE : {2'b00, root_q};
	assign uval    = neg ? -$signed(umag) : $signed(umag);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (req.start) state_d = F_SQ;
			F_SQ:    state_d = F_NRM;
			F_NRM:   state_d = F_LOAD;
			F_LOAD:  state_d = F_DIV;
			F_DIV:   if (cnt_q == '0) state_d = F_SQRT;
			F_SQRT:  if (cnt_q == '0) state_d = F_STORE;
			F_STORE: state_d = (k_q == 2'd2) ? F_IDLE : F_LOAD;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy     = state_q != F_IDLE;
		rsp.done = done_q;
		rsp.x    = ux_q;
		rsp.y    = uy_q;
		rsp.z    = uz_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == F_STORE) && (k_q == 2'd2);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				a_q <= req.a;
				b_q <= req.b;
				k_q <= 2'd0;
			end
			F_SQ: begin
				a2_q <= mag_a[HGT_W-1:0] * mag_a[HGT_W-1:0];
				b2_q <= mag_b[HGT_W-1:0] * mag_b[HGT_W-1:0];
			end
			F_NRM: n_q <= {1'b0, a2_q} + {1'b0, b2_q} + ONE_SQ;
			F_LOAD: begin
				rem_q <= csq;
				quo_q <= '0;
				cnt_q <= DIV_LAST;
			end
			F_DIV: begin
				rem_q <= r2_ge ? r2_sub[NSUM_W-1:0] : r2[NSUM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], r2_ge};
				if (cnt_q == '0) begin
					cnt_q  <= SQRT_LAST;
					srem_q <= '0;
					root_q <= '0;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
			F_SQRT: begin
				srem_q <= s_ge ? (s_in - s_trial) : s_in;
				root_q <= {root_q[ROOT_W-2:0], s_ge};
				quo_q  <= {quo_q[QUO_W-3:0], 2'b00};
				cnt_q  <= cnt_q - 5'd1;
			end
			F_STORE: begin
				unique case (k_q)
					2'd0:    ux_q <= uval;
					2'd1:    uy_q <= uval;
					default: uz_q <= uval;
				endcase
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("face done longer than one cycle");
	a_done_from_store: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == F_STORE && $past(k_q) == 2'd2))
		else $error("face done without final store");
	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && state_q == F_IDLE) |=> state_q == F_SQ)
		else $error("face start not taken");

endmodule
`default_nettype wire

// ----- rtl/heightmap_normal_generator.sv -----
// heightmap vertex normal generator: line memories, height scaling, face sum
// a new word is taken only once the last one is done, its faces passing one at a time through the shared face unit
// a word with no result (first row, dropped word) skips height scaling and the face unit
// reset clears the position counters, sets registers to defaults and clears the output valid
// the line memories are not cleared and hold no data until written
`default_nettype none
module heightmap_normal_generator #(
	parameter  int MAX_WIDTH = hnorm_pkg::MAX_WIDTH_DEF,
	localparam int CW  = $clog2(MAX_WIDTH),
	localparam int OW  = 3 * hnorm_pkg::NORM_W + CW + hnorm_pkg::LEN_W,
	localparam int ODW = ((OW + 7) / 8) * 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [hnorm_pkg::SMP_W-1:0]     s_tdata,  // height_sample
	input  wire logic                            s_tuser,  // action
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [ODW-1:0]                       m_tdata,  // normal_x, normal_y, normal_z, column, row
	output logic                                 m_tlast,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [hnorm_pkg::BASE_W-1:0]    cfg_data
);
	import hnorm_pkg::*;

	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > IMGW_W) ? WW : IMGW_W;

	hn_state_t state_q, state_d;

	logic [BASE_W-1:0] base_q;
	logic [IMGW_W-1:0] imgw_q;
	logic [LEN_W-1:0]  len_q;

	logic [CW-1:0]    col_q, fl_q, c_q;
	logic [LEN_W-1:0] row_q, row_out_q;
	logic act_q, res_q, has_l_q, has_r_q, has_u_q, last_q;
	logic [SMP_W-1:0] smp_q, smp_c_q, smp_u_q, smp_r_q, smp_lo_q, smp_l_q;

	logic [SMP_W-1:0] prev_mem [MAX_WIDTH];
	logic [SMP_W-1:0] old_mem  [MAX_WIDTH];
	logic [SMP_W-1:0] prev_rd_q, old_rd_q;
	logic [CW-1:0]    prev_ra, old_ra;
	logic             prev_re, old_re, mem_we;

	logic [PROD_W-1:0] prod_s1;
	logic [PROD_W+RCP_W-1:0] quot_full;
	logic [HGT_W-1:0] hgt_q [5];
	logic [2:0]       k_q;
	logic [SMP_W-1:0] hsel;

	logic [1:0] f_q;
	logic signed [NORM_W-1:0] acc_x_q, acc_y_q, acc_z_q;
	logic signed [DIFF_W-1:0] dl, dr, du, dd;
	logic f_en;
	face_req_t face_req;
	face_rsp_t face_rsp;
	logic face_busy;

	logic [CMPW-1:0] iw_ext;
	logic [WW-1:0]   w_eff;
	logic [LEN_W-1:0] len_eff;
	logic [CW-1:0]   c_in;
	logic            in_acc, drop, has_r_in, out_load;

	logic signed [NORM_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [CW-1:0]    out_col_q;
	logic [LEN_W-1:0] out_row_q;
	logic             out_last_q, out_valid_q;

	assign iw_ext  = CMPW'(imgw_q);
	assign w_eff   = (iw_ext == '0) ? WW'(1) :
	                 (iw_ext > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(iw_ext);
	assign len_eff = (len_q == '0) ? LEN_W'(1) : len_q;
	assign c_in    = s_tuser ? fl_q : col_q;
	assign has_r_in = (WW'(c_in) + WW'(1)) < w_eff;
	assign drop    = s_tuser ? (row_q < len_eff) : (row_q >= len_eff);
	assign in_acc  = s_tvalid && s_tready;

	// config
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			imgw_q <= IMGW_RST;
			len_q  <= LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BASE:   base_q <= cfg_data;
				REG_WIDTH:  imgw_q <= cfg_data[IMGW_W-1:0];
				REG_LENGTH: len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// line memories
	always_ff @(posedge clk) begin
		if (prev_re) prev_rd_q <= prev_mem[prev_ra];
		if (mem_we)  prev_mem[c_q] <= smp_q;
	end

	always_ff @(posedge clk) begin
		if (old_re) old_rd_q <= old_mem[old_ra];
		if (mem_we) old_mem[c_q] <= smp_c_q;
	end

	// height scaling and differences
	always_comb begin
		unique case (k_q)
			3'd0:    hsel = smp_c_q;
			3'd1:    hsel = smp_l_q;
			3'd2:    hsel = smp_r_q;
			3'd3:    hsel = smp_u_q;
			default: hsel = smp_q;
		endcase
	end

	assign quot_full = prod_s1 * RECIP_255;
	assign dl = $signed({1'b0, hgt_q[1]}) - $signed({1'b0, hgt_q[0]});
	assign dr = $signed({1'b0, hgt_q[2]}) - $signed({1'b0, hgt_q[0]});
	assign du = $signed({1'b0, hgt_q[3]}) - $signed({1'b0, hgt_q[0]});
	assign dd = $signed({1'b0, hgt_q[4]}) - $signed({1'b0, hgt_q[0]});

	// face select: upper-left, left-lower, lower-right, right-upper
	always_comb begin
		unique case (f_q)
			2'd0: begin
				f_en = has_u_q && has_l_q;
				face_req.a = dl;
				face_req.b = du;
			end
			2'd1: begin
				f_en = has_l_q && !act_q;
				face_req.a = dl;
				face_req.b = -dd;
			end
			2'd2: begin
				f_en = !act_q && has_r_q;
				face_req.a = -dr;
				face_req.b = -dd;
			end
			default: begin
				f_en = has_r_q && has_u_q;
				face_req.a = -dr;
				face_req.b = du;
			end
		endcase
		face_req.start = (state_q == ST_FSEL) && f_en;
	end

	hnorm_face u_face (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (face_req),
		.rsp    (face_rsp),
		.busy   (face_busy)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_acc && !drop) state_d = ST_RD0;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = res_q ? ST_HMUL : ST_IDLE;
			ST_HMUL:  state_d = ST_HDIV;
			ST_HDIV:  state_d = (k_q == 3'd4) ? ST_FSEL : ST_HMUL;
			ST_FSEL: begin
				if (f_en)              state_d = ST_FWAIT;
				else if (f_q == 2'd3)  state_d = ST_EMIT;
			end
			ST_FWAIT: begin
				if (face_rsp.done) state_d = (f_q == 2'd3) ? ST_EMIT : ST_FSEL;
			end
			ST_EMIT:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = state_q == ST_IDLE;
		prev_re  = (state_q == ST_RD0) || (state_q == ST_RD1) || (state_q == ST_RD2);
		old_re   = (state_q == ST_RD0) || (state_q == ST_RD1);
		mem_we   = (state_q == ST_RD3) && !act_q;
		prev_ra  = c_q;
		old_ra   = c_q;
		if (state_q == ST_RD1) begin
			prev_ra = c_q + CW'(1);
			old_ra  = c_q - CW'(1);
		end else if (state_q == ST_RD2) begin
			prev_ra = c_q - CW'(1);
		end
		out_load = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			fl_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && !drop) begin
				if (!s_tuser) begin
					if (!has_r_in) begin
						col_q <= '0;
						row_q <= row_q + LEN_W'(1);
					end else begin
						col_q <= c_in + CW'(1);
					end
				end else if (!has_r_in) begin
					col_q <= '0;
					row_q <= '0;
					fl_q  <= '0;
				end else begin
					fl_q <= c_in + CW'(1);
				end
			end
			if (out_load)       out_valid_q <= 1'b1;
			else if (m_tready)  out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q     <= s_tuser;
			smp_q     <= s_tdata;
			c_q       <= c_in;
			res_q     <= s_tuser || (row_q != '0);
			has_l_q   <= c_in != '0;
			has_r_q   <= has_r_in;
			has_u_q   <= row_q >= LEN_W'(2);
			row_out_q <= row_q - LEN_W'(1);
			last_q    <= s_tuser && !has_r_in;
			k_q       <= '0;
			f_q       <= '0;
			acc_x_q   <= '0;
			acc_y_q   <= '0;
			acc_z_q   <= '0;
		end
		if (state_q == ST_RD1) begin
			smp_c_q <= prev_rd_q;
			smp_u_q <= old_rd_q;
		end
		if (state_q == ST_RD2) begin
			smp_r_q  <= prev_rd_q;
			smp_lo_q <= old_rd_q;
		end
		if (state_q == ST_RD3) smp_l_q <= act_q ? prev_rd_q : smp_lo_q;
		if (state_q == ST_HMUL) prod_s1 <= PROD_W'(base_q) * PROD_W'(hsel) + ROUND_ADD;
		if (state_q == ST_HDIV) begin
			hgt_q[k_q] <= quot_full[RCP_SH +: HGT_W];
			k_q        <= k_q + 3'd1;
		end
		if (state_q == ST_FSEL && !f_en && f_q != 2'd3) f_q <= f_q + 2'd1;
		if (state_q == ST_FWAIT && face_rsp.done) begin
			acc_x_q <= acc_x_q + NORM_W'(face_rsp.x);
			acc_y_q <= acc_y_q + NORM_W'(face_rsp.y);
			acc_z_q <= acc_z_q + NORM_W'(face_rsp.z);
			if (f_q != 2'd3) f_q <= f_q + 2'd1;
		end
		if (out_load) begin
			out_x_q    <= acc_x_q;
			out_y_q    <= acc_y_q;
			out_z_q    <= acc_z_q;
			out_col_q  <= c_q;
			out_row_q  <= row_out_q;
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ODW'({out_row_q, out_col_q, out_z_q, out_y_q, out_x_q});
	assign m_tlast  = out_last_q;

	a_face_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		face_busy |-> state_q == ST_FWAIT) else $error("face unit busy outside wait");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready)) else $error("output word overwritten");
	a_write_sample_only: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_RD3 && !act_q)) else $error("line write on flush");

endmodule
`default_nettype wire

// ----- test/heightmap_normal_generator_tb.sv -----
// self-checking testbench for the heightmap normal generator with a built-in normal predictor
`default_nettype none
module heightmap_normal_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hnorm_pkg::*;

	localparam int MAXW = 1024;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE = 700;

	typedef struct packed {
		logic signed [NORM_W-1:0] nx;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nz;
		logic [9:0]               col;
		logic [15:0]              row;
		logic                     last;
	} normal_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_BASE;
	logic [15:0] cfg_data = '0;

	heightmap_normal_generator u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int unsigned base_height = 256;
	int unsigned image_width = 1024;
	int unsigned image_length = 1024;
	logic [7:0]  prev_line [MAXW];
	logic [7:0]  older_line [MAXW];
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	int unsigned flush_pos = 0;

	normal_t pending_normals[$];
	int mismatches = 0;
	int normals_seen = 0;
	int words_sent = 0;
	int frames_done = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int quiet_cycles = 0;

	function automatic void queue_normal(normal_t item);
		pending_normals.insert(pending_normals.size(), item);
	endfunction

	function automatic int scaled_height(logic [7:0] s);
		return int'((base_height * s + 127) / 255);
	endfunction

	function automatic int unit_comp(int c, longint unsigned n);
		longint unsigned mag, target, lo, hi, mid;
		mag = (c < 0) ? longint'(-c) : longint'(c);
		target = (mag * mag) << 28;
		lo = 0;
		hi = 16384;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid * n <= target) lo = mid;
			else hi = mid - 1;
		end
		return (c < 0) ? -int'(lo) : int'(lo);
	endfunction

	function automatic void add_face(ref int acc[3], input int a, input int b);
		longint unsigned n;
		n = longint'(a) * a + 65536 + longint'(b) * b;
		acc[0] += unit_comp(a, n);
		acc[1] += unit_comp(256, n);
		acc[2] += unit_comp(b, n);
	endfunction

	function automatic normal_t face_sum(int hc, int hl, int hr, int hu, int hd,
			bit l, bit r, bit u, bit d, int col, int row, bit last);
		int acc[3];
		normal_t n;
		acc = '{0, 0, 0};
		if (u && l) add_face(acc, hl - hc, hu - hc);
		if (l && d) add_face(acc, hl - hc, hc - hd);
		if (d && r) add_face(acc, hc - hr, hc - hd);
		if (r && u) add_face(acc, hc - hr, hu - hc);
		n.nx = acc[0][NORM_W-1:0];
		n.ny = acc[1][NORM_W-1:0];
		n.nz = acc[2][NORM_W-1:0];
		n.col = col[9:0];
		n.row = row[15:0];
		n.last = last;
		return n;
	endfunction

	task automatic predict_word(bit is_flush, logic [7:0] s);
		int unsigned w, len, c, r;
		int hu, hc, hl, hr;
		bit l, rt;
		w = (image_width == 0) ? 1 : (image_width > MAXW ? MAXW : image_width);
		len = (image_length == 0) ? 1 : image_length;
		hl = 0;
		hr = 0;
		if (!is_flush) begin
			c = col_pos % MAXW;
			r = row_pos;
			l = c > 0;
			rt = c + 1 < w;
			if (r >= len) return;
			hu = scaled_height(older_line[c]);
			hc = scaled_height(prev_line[c]);
			if (rt) hr = scaled_height(prev_line[c+1]);
			if (l) hl = scaled_height(older_line[c-1]);
			older_line[c] = prev_line[c];
			prev_line[c] = s;
			if (r >= 1)
				queue_normal(face_sum(hc, hl, hr, hu, scaled_height(s),
					l, rt, r > 1, 1'b1, c, r - 1, 1'b0));
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = r + 1;
			end else begin
				col_pos = c + 1;
			end
		end else begin
			c = flush_pos % MAXW;
			l = c > 0;
			rt = c + 1 < w;
			if (row_pos < len) return;
			r = row_pos - 1;
			hu = scaled_height(older_line[c]);
			hc = scaled_height(prev_line[c]);
			if (rt) hr = scaled_height(prev_line[c+1]);
			if (l) hl = scaled_height(prev_line[c-1]);
			queue_normal(face_sum(hc, hl, hr, hu, 0, l, rt, r > 0, 1'b0,
				c, r, !rt));
			if (!rt) begin
				col_pos = 0;
				row_pos = 0;
				flush_pos = 0;
				frames_done++;
			end else begin
				flush_pos = c + 1;
			end
		end
	endtask

	task automatic send_word(bit is_flush, logic [7:0] s);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = is_flush;
		s_tdata = s;
		do @(posedge clk); while (!s_tready);
		predict_word(is_flush, s);
		words_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_normals.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BASE: base_height = val;
			REG_WIDTH: image_width = val[10:0];
			REG_LENGTH: image_length = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_frame(int unsigned base, int unsigned w, int unsigned len);
		wait_drained();
		write_reg(REG_BASE, base[15:0]);
		write_reg(REG_WIDTH, w[15:0]);
		write_reg(REG_LENGTH, len[15:0]);
	endtask

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// full frame with optional stray words that must be dropped
	task automatic send_frame(int unsigned w, int unsigned len, bit noisy);
		for (int r = 0; r < len; r++)
			for (int c = 0; c < w; c++) begin
				if (noisy && $urandom_range(19) == 0) send_word(1'b1, 8'($urandom));
				send_word(1'b0, pick_sample());
			end
		if (noisy && $urandom_range(4) == 0) send_word(1'b0, 8'($urandom));
		for (int c = 0; c < w; c++) send_word(1'b1, 8'($urandom));
	endtask

	task automatic test_directed();
		set_frame(65535, 3, 3);
		send_word(1'b1, 8'hff);
		for (int i = 0; i < 9; i++) send_word(1'b0, (i % 2) ? 8'd255 : 8'd0);
		send_word(1'b0, 8'h5a);
		for (int i = 0; i < 3; i++) send_word(1'b1, 8'h00);
		set_frame(0, 2, 2);
		for (int i = 0; i < 4; i++) send_word(1'b0, 8'($urandom));
		for (int i = 0; i < 2; i++) send_word(1'b1, 8'h00);
	endtask

	task automatic test_single_column();
		set_frame(12345, 0, 0);
		send_word(1'b0, 8'd200);
		send_word(1'b1, 8'h00);
		set_frame(40000, 1, 65535);
		for (int i = 0; i < 3; i++) send_word(1'b0, pick_sample());
		send_word(1'b1, 8'h00);
		wait_drained();
		write_reg(REG_LENGTH, 16'd2);
		send_word(1'b0, 8'd77);
		send_word(1'b1, 8'h00);
	endtask

	task automatic test_wide_frame();
		set_frame(300, 96, 2);
		send_frame(96, 2, 1'b0);
	endtask

	task automatic test_random_frames(int sidle, int ridle, int quota, bit pause_once);
		int target, w, len, base;
		send_idle = sidle;
		recv_idle = ridle;
		target = words_sent + quota;
		while (words_sent < target) begin
			w = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
			len = $urandom_range(1, 5);
			case ($urandom_range(4))
				0: base = 0;
				1: base = 65535;
				default: base = $urandom_range(65535);
			endcase
			set_frame(base, w, len);
			if (pause_once) begin
				send_word(1'b0, pick_sample());
				wait_drained();
				pause_once = 1'b0;
				for (int i = 1; i < w * len; i++) send_word(1'b0, pick_sample());
				for (int i = 0; i < w; i++) send_word(1'b1, 8'h00);
			end else begin
				send_frame(w, len, 1'b1);
			end
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		normal_t got, want;
		if (m_tvalid && m_tready) begin
			got.nx = m_tdata[17:0];
			got.ny = m_tdata[35:18];
			got.nz = m_tdata[53:36];
			got.col = m_tdata[63:54];
			got.row = m_tdata[79:64];
			got.last = m_tlast;
			normals_seen++;
			if (pending_normals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: col %0d row %0d", got.col, got.row);
			end else begin
				want = pending_normals.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x %0d y %0d z %0d col %0d row %0d last %0b, got x %0d y %0d z %0d col %0d row %0d last %0b",
							want.nx, want.ny, want.nz, want.col, want.row, want.last,
							got.nx, got.ny, got.nz, got.col, got.row, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("heightmap_normal_generator test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAXW; i++) begin
			prev_line[i] = '0;
			older_line[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_single_column();
		test_random_frames(37, 83, 190, 1'b1);
		test_random_frames(83, 37, 190, 1'b0);
		test_random_frames(0, 0, 190, 1'b0);
		test_wide_frame();
		wait_drained();
		$display("covered %0d input words and %0d normals over %0d frames", words_sent,
			normals_seen, frames_done);
		$display("edge pixels, dropped words, zero and extreme register values, three stall mixes");
		if (mismatches == 0 && pending_normals.size() == 0) begin
			$display("heightmap_normal_generator test passed");
		end else begin
			$display("%0d mismatches, %0d normals missing", mismatches, pending_normals.size());
			$display("heightmap_normal_generator test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/hnorm_pkg.sv
rtl/hnorm_face.sv
rtl/heightmap_normal_generator.sv
test/heightmap_normal_generator_tb.sv
